// ===== hdl/hdwt_pkg.sv =====
// ----------------------------------------------------------------------------
// hdwt_pkg: shared types and constants for the 8x8 Haar transform core
// Sizes, the butterfly constant and the sequencer state type.
// ----------------------------------------------------------------------------
package hdwt_pkg;

	localparam int BlockDim    = 8;
	localparam int SampleWidth = 20;
	localparam int NElem       = BlockDim * BlockDim;
	localparam int AddrWidth   = $clog2(NElem);
	localparam int DimWidth    = $clog2(BlockDim);
	localparam int LvlTop      = DimWidth - 1;
	localparam int InvSqrt2Q16 = 46341;

	typedef logic signed [SampleWidth-1:0] sample_t;
	typedef logic [AddrWidth-1:0] addr_t;
	typedef logic [DimWidth-1:0] dim_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RD_A,
		ST_RD_B,
		ST_MUL,
		ST_WR,
		ST_OUT
	} seq_state_t;

	// Butterfly request from sequencer to arithmetic unit.
	typedef struct packed {
		logic sub;
		logic start;
	} bfly_ctl_t;

endpackage

// ===== hdl/hdwt_bfly.sv =====
// ----------------------------------------------------------------------------
// hdwt_bfly: shared butterfly unit
// Computes saturate(round((a +/- b) / sqrt2)); the sum is registered.
// ----------------------------------------------------------------------------
module hdwt_bfly
	import hdwt_pkg::*;
(
	input  logic      clk,
	input  bfly_ctl_t ctl,
	input  sample_t   a,
	input  sample_t   b,
	output sample_t   y
);

	localparam int SumWidth  = SampleWidth + 1;
	localparam int ProdWidth = SumWidth + 17;

	logic signed [SumWidth-1:0]  sum_q;
	logic signed [ProdWidth-1:0] prod;
	logic signed [ProdWidth-17:0] shr;
	logic signed [ProdWidth-17:0] hi_lim;
	logic signed [ProdWidth-17:0] lo_lim;

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			if (ctl.sub) begin
				sum_q <= SumWidth'(a) - SumWidth'(b);
			end else begin
				sum_q <= SumWidth'(a) + SumWidth'(b);
			end
		end
	end

	always_comb begin
		prod   = ProdWidth'(sum_q) * $signed({1'b0, 16'(InvSqrt2Q16)})
			+ ProdWidth'(32768);
		shr    = prod[ProdWidth-1:16];
		hi_lim = (ProdWidth-16)'({1'b0, {(SampleWidth-1){1'b1}}});
		lo_lim = -hi_lim - (ProdWidth-16)'(1);
		if (shr > hi_lim) begin
			y = {1'b0, {(SampleWidth-1){1'b1}}};
		end else if (shr < lo_lim) begin
			y = {1'b1, {(SampleWidth-1){1'b0}}};
		end else begin
			y = shr[SampleWidth-1:0];
		end
	end

endmodule

// ===== hdl/hdwt_seq.sv =====
// ----------------------------------------------------------------------------
// hdwt_seq: transform sequencer and block store
// Loads 64 samples, walks the passes through the shared butterfly, then
// drains the block in row-major order.
// ----------------------------------------------------------------------------
module hdwt_seq
	import hdwt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      inv_mode,
	input  logic      in_valid,
	input  sample_t   in_sample,
	output logic      in_stall,
	output bfly_ctl_t bctl,
	output sample_t   op_a,
	output sample_t   op_b,
	input  sample_t   bres,
	output logic      out_valid,
	input  logic      out_stall,
	output sample_t   out_coef,
	output addr_t     out_pos,
	output logic      out_last
);

	seq_state_t state_q, state_d;
	sample_t mem [NElem];
	sample_t rd_q, a_q;
	addr_t   cnt_q;
	logic    inv_q;
	logic [1:0] lvl_q;       // 0..2 : size = 8 >> lvl
	logic    col_q;          // current pass is along columns
	dim_t    line_q, k_q;
	logic    half_q;         // 0 writes sum, 1 writes difference
	logic    ov_q;           // output register valid
	sample_t oc_q;
	addr_t   op_q;
	logic    rd_pend_q;
	addr_t   rd_pend_addr_q;
	logic    iss_done_q;     // every drain read of the block has been issued

	sample_t tmp [BlockDim];
	logic [3:0] size;
	dim_t hsz;
	dim_t ia, ib, iw;
	addr_t ra, rb;
	logic last_k, last_line, last_pass, last_lvl;
	logic take, issue, load_out;

	assign size = 4'(BlockDim >> lvl_q);
	assign hsz  = dim_t'(size >> 1);

	// pair indices within a line
	always_comb begin
		if (inv_q) begin
			ia = k_q;
			ib = k_q + hsz;
			iw = dim_t'({k_q, 1'b0}) | dim_t'(half_q);
		end else begin
			ia = dim_t'({k_q, 1'b0});
			ib = dim_t'({k_q, 1'b1});
			iw = half_q ? k_q + hsz : k_q;
		end
	end

	function automatic addr_t at(logic c, dim_t ln, dim_t p);
		return c ? addr_t'({p, ln}) : addr_t'({ln, p});
	endfunction

	assign ra = at(col_q, line_q, ia);
	assign rb = at(col_q, line_q, ib);

	// Line results go into a small buffer and are written back after the line.
	logic wb_q;
	dim_t wbi_q;

	assign take     = ov_q && !out_stall;
	assign load_out = (state_q == ST_OUT) && rd_pend_q && (!ov_q || take);
	assign issue    = (state_q == ST_OUT) && !iss_done_q && (!rd_pend_q || load_out);

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && in_valid) begin
			mem[cnt_q] <= in_sample;
		end else if (wb_q) begin
			mem[at(col_q, line_q, wbi_q)] <= tmp[wbi_q];
		end
		case (state_q)
			ST_RD_A: rd_q <= mem[ra];
			ST_RD_B: rd_q <= mem[rb];
			ST_OUT:  if (issue) rd_q <= mem[cnt_q];
			default: ;
		endcase
		if (state_q == ST_RD_B) a_q <= rd_q;
		if (state_q == ST_WR) tmp[iw] <= bres;
	end

	assign op_a = a_q;
	assign op_b = rd_q;
	assign bctl.start = (state_q == ST_MUL);
	assign bctl.sub = half_q;

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		case (state_q)
			ST_LOAD: begin
				in_stall = 1'b0;
				if (in_valid && cnt_q == addr_t'(NElem-1)) state_d = ST_RD_A;
			end
			ST_RD_A: begin
				if (!wb_q) begin
					state_d = ST_RD_B;
				end else if (wbi_q == dim_t'(size - 4'd1) && last_line && last_pass
					&& last_lvl) begin
					state_d = ST_OUT;
				end
			end
			ST_RD_B: state_d = ST_MUL;
			ST_MUL:  state_d = ST_WR;
			ST_WR: begin
				if (!half_q) state_d = ST_MUL;
				else state_d = ST_RD_A;
			end
			ST_OUT: if (iss_done_q && !rd_pend_q && !ov_q) state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	// last pair of line and last line / pass / level decisions
	assign last_k    = (k_q == hsz - dim_t'(1));
	assign last_line = (line_q == dim_t'(size - 4'd1));
	assign last_pass = inv_q ? !col_q : col_q;
	assign last_lvl  = inv_q ? (lvl_q == 2'd0) : (lvl_q == 2'(LvlTop));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q <= '0;
			inv_q <= 1'b0;
			lvl_q <= '0;
			col_q <= 1'b0;
			line_q <= '0;
			k_q <= '0;
			half_q <= 1'b0;
			ov_q <= 1'b0;
			wb_q <= 1'b0;
			wbi_q <= '0;
			rd_pend_q <= 1'b0;
			rd_pend_addr_q <= '0;
			iss_done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						cnt_q <= cnt_q + addr_t'(1);
						if (cnt_q == addr_t'(NElem-1)) begin
							inv_q <= inv_mode;
							lvl_q <= inv_mode ? 2'(LvlTop) : 2'd0;
							col_q <= inv_mode;
							line_q <= '0;
							k_q <= '0;
							half_q <= 1'b0;
							iss_done_q <= 1'b0;
						end
					end
				end
				ST_MUL: ;
				ST_WR: begin
					half_q <= ~half_q;
					if (half_q) begin
						if (last_k) begin
							k_q <= '0;
							wb_q <= 1'b1;
							wbi_q <= '0;
						end else begin
							k_q <= k_q + dim_t'(1);
						end
					end
				end
				ST_RD_A: begin
					if (wb_q) begin
						// write back buffered line, one element per cycle
						if (wbi_q == dim_t'(size - 4'd1)) begin
							wb_q <= 1'b0;
							if (last_line) begin
								line_q <= '0;
								if (last_pass) begin
									if (last_lvl) begin
										cnt_q <= '0;
									end else begin
										lvl_q <= inv_q ? lvl_q - 2'd1 : lvl_q + 2'd1;
										col_q <= inv_q;
									end
								end else begin
									col_q <= ~col_q;
								end
							end else begin
								line_q <= line_q + dim_t'(1);
							end
						end else begin
							wbi_q <= wbi_q + dim_t'(1);
						end
					end
				end
				ST_OUT: begin
					// issue the next read whenever the read register frees up
					if (issue) begin
						rd_pend_q <= 1'b1;
						rd_pend_addr_q <= cnt_q;
						cnt_q <= cnt_q + addr_t'(1);
						if (cnt_q == addr_t'(NElem-1)) iss_done_q <= 1'b1;
					end else if (load_out) begin
						rd_pend_q <= 1'b0;
					end
				end
				default: ;
			endcase
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (take) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			oc_q <= rd_q;
			op_q <= rd_pend_addr_q;
		end
	end

	assign out_valid = ov_q;
	assign out_coef  = oc_q;
	assign out_pos   = op_q;
	assign out_last  = (op_q == addr_t'(NElem-1));

endmodule

// ===== hdl/haar_dwt_8x8_block_core.sv =====
// ----------------------------------------------------------------------------
// haar_dwt_8x8_block_core: three-level 2D Haar transform of an 8x8 block
// Loads 64 samples, transforms forward or inverse, emits 64 values.
// ----------------------------------------------------------------------------
// One block is loaded at one sample per cycle. The transform then runs 84
// butterfly pairs through a single shared add/multiply unit; each pair takes
// two reads from the block store and two multiply/write steps into a line
// buffer, and every finished line is written back to the store element by
// element. Results then drain at up to one per cycle while out_stall is low,
// each passing through a read register and then the output register. The
// input is stalled from the last sample until the final result of the block
// has been taken and the sequencer has returned to loading. inverse_mode is
// sampled with the last sample.
module haar_dwt_8x8_block_core
	import hdwt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_we,
	input  logic    cfg_wdata,
	input  logic    in_valid,
	output logic    in_stall,
	input  sample_t sample,
	output logic    out_valid,
	input  logic    out_stall,
	output sample_t coefficient,
	output addr_t   position,
	output logic    last
);

	logic inverse_mode_q;
	bfly_ctl_t bctl;
	sample_t op_a, op_b, bres;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_mode_q <= 1'b0;
		end else if (cfg_we) begin
			inverse_mode_q <= cfg_wdata;
		end
	end

	hdwt_seq u_seq (
		.clk(clk), .arst_n(arst_n), .inv_mode(inverse_mode_q),
		.in_valid(in_valid), .in_sample(sample), .in_stall(in_stall),
		.bctl(bctl), .op_a(op_a), .op_b(op_b), .bres(bres),
		.out_valid(out_valid), .out_stall(out_stall), .out_coef(coefficient),
		.out_pos(position), .out_last(last)
	);

	hdwt_bfly u_bfly (
		.clk(clk), .ctl(bctl), .a(op_a), .b(op_b), .y(bres)
	);

endmodule

// ===== hdl/hdwt_chk.sv =====
// ----------------------------------------------------------------------------
// hdwt_chk: port-level checks for the Haar transform core
// Watches handshakes and output ordering.
// ----------------------------------------------------------------------------
module hdwt_chk
	import hdwt_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    in_stall,
	input logic    out_valid,
	input logic    out_stall,
	input sample_t coefficient,
	input addr_t   position,
	input logic    last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(coefficient))
		else $error("stalled result changed");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (position == addr_t'(NElem-1))))
		else $error("last flag mismatch");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> !out_valid ||
		position == $past(position) + addr_t'(1))
		else $error("result order broken");

	a_noload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while draining");

endmodule

bind haar_dwt_8x8_block_core hdwt_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .coefficient(coefficient),
	.position(position), .last(last)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 8x8 three-level Haar transform core
// Streams blocks of samples with random idling on both sides, predicts every
// coefficient with a bit-exact model of the butterfly arithmetic, and checks
// value, position and last flag of each result in order.
// ----------------------------------------------------------------------------
module tb;
	import hdwt_pkg::*;

	typedef struct {
		sample_t coef;
		addr_t   pos;
		logic    lst;
	} coef_rec_t;

	class haar_scoreboard;
		sample_t   blk [NElem];
		int        fill;
		logic      inv;
		coef_rec_t pending [$];
		int        errors;

		function new();
			fill = 0;
			inv = 1'b0;
			errors = 0;
		endfunction

		function automatic sample_t bfly(longint a, longint b, bit sub);
			longint s;
			longint p;
			longint q;
			longint hi;
			s = sub ? a - b : a + b;
			p = s * InvSqrt2Q16 + 32768;
			q = p >>> 16;
			hi = (longint'(1) << (SampleWidth - 1)) - 1;
			if (q > hi)
				q = hi;
			if (q < -hi - 1)
				q = -hi - 1;
			return sample_t'(q);
		endfunction

		// Transform one line of n elements in place along the given stride.
		function automatic void line_pass(int base, int stride, int n, bit inverse);
			sample_t t [BlockDim];
			int      h;
			h = n / 2;
			for (int k = 0; k < h; k++) begin
				if (!inverse) begin
					t[k]     = bfly(blk[base + 2*k*stride], blk[base + (2*k+1)*stride], 0);
					t[k + h] = bfly(blk[base + 2*k*stride], blk[base + (2*k+1)*stride], 1);
				end else begin
					t[2*k]   = bfly(blk[base + k*stride], blk[base + (k+h)*stride], 0);
					t[2*k+1] = bfly(blk[base + k*stride], blk[base + (k+h)*stride], 1);
				end
			end
			for (int k = 0; k < 2*h; k++)
				blk[base + k*stride] = t[k];
		endfunction

		function automatic void pass_all(int size, bit rows, bit inverse);
			for (int i = 0; i < size; i++) begin
				if (rows)
					line_pass(i * BlockDim, 1, size, inverse);
				else
					line_pass(i, BlockDim, size, inverse);
			end
		endfunction

		function automatic void note_sample(sample_t s);
			coef_rec_t r;
			blk[fill] = s;
			fill++;
			if (fill < NElem)
				return;
			fill = 0;
			if (!inv) begin
				for (int sz = BlockDim; sz >= 2; sz /= 2) begin
					pass_all(sz, 1, 0);
					pass_all(sz, 0, 0);
				end
			end else begin
				for (int sz = 2; sz <= BlockDim; sz *= 2) begin
					pass_all(sz, 0, 1);
					pass_all(sz, 1, 1);
				end
			end
			for (int i = 0; i < NElem; i++) begin
				r.coef = blk[i];
				r.pos = addr_t'(i);
				r.lst = (i == NElem - 1);
				pending.push_back(r);
			end
		endfunction

		function automatic void check_result(sample_t c, addr_t p, logic l);
			coef_rec_t e;
			if (pending.size() == 0) begin
				$error("unexpected result coefficient=%0d position=%0d", c, p);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (c !== e.coef) begin
				$error("coefficient: expected %0d, actual %0d", e.coef, c);
				errors++;
			end
			if (p !== e.pos) begin
				$error("position: expected %0d, actual %0d", e.pos, p);
				errors++;
			end
			if (l !== e.lst) begin
				$error("last: expected %0d, actual %0d", e.lst, l);
				errors++;
			end
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    cfg_we;
	logic    cfg_wdata;
	logic    in_valid;
	logic    in_stall;
	sample_t sample;
	logic    out_valid;
	logic    out_stall;
	sample_t coefficient;
	addr_t   position;
	logic    last;

	haar_scoreboard sb;
	bit  idle_on;
	int  hold_req;
	int  quiet_cycles = 0;

	localparam int WatchLimit = 20000;

	haar_dwt_8x8_block_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.coefficient(coefficient), .position(position), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Sample results and watch for progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(coefficient, position, last);
			if ((out_valid && !out_stall) || (in_valid && !in_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles >= WatchLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: random stall bursts, plus a long hold-off on request.
	initial begin
		int n;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				out_stall <= 1'b1;
				n = hold_req;
				hold_req = 0;
				repeat (n - 1) @(negedge clk);
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 6);
				out_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_sample(sample_t s);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_sample(s);
		@(negedge clk);
	endtask

	task automatic drain_all();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		// block is stalled until its last result is taken; a short pad suffices
		repeat (20) @(negedge clk);
	endtask

	task automatic set_mode(logic m);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.inv = m;
	endtask

	function automatic sample_t rand_sample();
		case ($urandom_range(0, 5))
			0: return sample_t'(-524288);
			1: return sample_t'(524287);
			2: return sample_t'($urandom_range(0, 127)) - sample_t'(64);
			default: return sample_t'($urandom());
		endcase
	endfunction

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		idle_on = 1'b0;
		hold_req = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: all-max then all-min block, forward, no idling.
		set_mode(1'b0);
		for (int i = 0; i < NElem; i++)
			send_sample(i < 32 ? sample_t'(524287) : sample_t'(-524288));
		drain_all();

		// Inverse of an alternating extreme pattern to exercise saturation.
		set_mode(1'b1);
		for (int i = 0; i < NElem; i++)
			send_sample(i[0] ? sample_t'(-524288) : sample_t'(524287));
		drain_all();

		// Random blocks with idling and a random mode, written only while idle.
		// The third block is offered while the second one is held off.
		idle_on = 1'b1;
		for (int b = 0; b < 3; b++) begin
			if (b != 2) begin
				drain_all();
				set_mode($urandom_range(0, 1));
			end
			for (int i = 0; i < NElem; i++) begin
				send_sample(rand_sample());
				if (b == 1 && i == NElem - 1)
					hold_req = 1000;
			end
		end
		drain_all();

		// Final block without idling.
		idle_on = 1'b0;
		set_mode(1'b0);
		for (int i = 0; i < NElem; i++)
			send_sample(rand_sample());
		drain_all();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
